>>> hw/rtl/rrsr_pkg.sv
package rrsr_pkg;

    localparam int POP_SIZE   = 16;
    localparam int SLOT_W     = $clog2(POP_SIZE);
    localparam int CNT_W      = $clog2(POP_SIZE + 1);
    localparam int HALF_POP   = POP_SIZE / 2;
    localparam int SCORE_W    = 32;
    localparam int IN_SCORE_W = 16;
    localparam int ID_W       = 4;
    localparam int KIND_W     = 2;
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = $clog2(Q_DEPTH);
    localparam int Q_CW       = $clog2(Q_DEPTH + 1);

    localparam logic OPER_START = 1'b0;
    localparam logic OPER_FIGHT = 1'b1;

    localparam logic [KIND_W-1:0] KIND_FIGHT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BREED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    typedef struct packed {
        logic                  operation;
        logic [IN_SCORE_W-1:0] first_score;
        logic [IN_SCORE_W-1:0] second_score;
    } t_in_req;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   first_id;
        logic [ID_W-1:0]   second_id;
        logic              last;
    } t_out_res;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_FIGHT,
        CMD_ERROR
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op               op;
        logic [SLOT_W-1:0]     low;
        logic [SLOT_W-1:0]     high;
        logic [SLOT_W-1:0]     nxt_low;
        logic [SLOT_W-1:0]     nxt_high;
        logic                  last_pair;
        logic [IN_SCORE_W-1:0] s1;
        logic [IN_SCORE_W-1:0] s2;
    } t_cmd;

    typedef enum logic [3:0] {
        B_IDLE,
        B_PEMIT,
        B_ADD_LO,
        B_ADD_HI,
        B_SLD,
        B_SCAP,
        B_SRD,
        B_SCMP,
        B_SWI,
        B_BRD,
        B_BEMIT
    } t_back_state;

endpackage

>>> hw/rtl/rrsr_front.sv
module rrsr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rrsr_pkg::t_in_req i_req,
    output rrsr_pkg::t_cmd  o_cmd
);
    import rrsr_pkg::*;

    logic             r_open;
    logic [CNT_W-1:0] r_low;
    logic [CNT_W-1:0] r_high;
    logic             n_open;
    logic [CNT_W-1:0] n_low;
    logic [CNT_W-1:0] n_high;
    logic [CNT_W-1:0] step_low;
    logic [CNT_W-1:0] step_high;
    logic             step_last;

    always_comb begin
        step_low  = r_low;
        step_high = r_high + CNT_W'(1);
        if (step_high >= CNT_W'(POP_SIZE)) begin
            step_low  = r_low + CNT_W'(1);
            step_high = r_low + CNT_W'(2);
        end
        step_last = (step_high >= CNT_W'(POP_SIZE));
    end

    always_comb begin
        n_open          = r_open;
        n_low           = r_low;
        n_high          = r_high;
        o_cmd.op        = CMD_ERROR;
        o_cmd.low       = SLOT_W'(r_low);
        o_cmd.high      = SLOT_W'(r_high);
        o_cmd.nxt_low   = SLOT_W'(step_low);
        o_cmd.nxt_high  = SLOT_W'(step_high);
        o_cmd.last_pair = step_last;
        o_cmd.s1        = i_req.first_score;
        o_cmd.s2        = i_req.second_score;
        if (i_req.operation == OPER_START) begin
            o_cmd.op = CMD_START;
            if (i_push) begin
                n_open = 1'b1;
                n_low  = '0;
                n_high = CNT_W'(1);
            end
        end else if (r_open) begin
            o_cmd.op = CMD_FIGHT;
            if (i_push) begin
                n_low  = step_low;
                n_high = step_high;
                if (step_last) begin
                    n_open = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_low  <= '0;
            r_high <= CNT_W'(1);
        end else begin
            r_open <= n_open;
            r_low  <= n_low;
            r_high <= n_high;
        end
    end

endmodule

>>> hw/rtl/rrsr_cmd_q.sv
module rrsr_cmd_q (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rrsr_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output rrsr_pkg::t_cmd o_cmd
);
    import rrsr_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_CW-1:0] r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd + Q_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + Q_CW'(1);
                2'b01:   r_cnt <= r_cnt - Q_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> hw/rtl/rrsr_back.sv
module rrsr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  rrsr_pkg::t_cmd     i_cmd,
    output logic               o_pop,
    output logic               o_res_valid,
    output rrsr_pkg::t_out_res o_res
);
    import rrsr_pkg::*;

    // score and ranking stores, two registered read ports each
    logic [SCORE_W-1:0] r_sc_mem [POP_SIZE];
    logic [SLOT_W-1:0]  r_od_mem [POP_SIZE];
    logic [POP_SIZE-1:0] r_sc_vld;
    logic [POP_SIZE-1:0] r_od_vld;

    logic [SCORE_W-1:0] r_sc_a;
    logic [SCORE_W-1:0] r_sc_b;
    logic               r_sc_va;
    logic               r_sc_vb;
    logic [SLOT_W-1:0]  r_od_a;
    logic [SLOT_W-1:0]  r_od_b;
    logic               r_od_va;
    logic               r_od_vb;
    logic [SLOT_W-1:0]  r_od_aa;
    logic [SLOT_W-1:0]  r_od_ab;

    t_back_state        r_state;
    t_back_state        n_state;
    t_cmd               r_cmd;
    t_cmd               n_cmd;
    logic [SLOT_W-1:0]  r_i;
    logic [SLOT_W-1:0]  n_i;
    logic [SLOT_W-1:0]  r_j;
    logic [SLOT_W-1:0]  n_j;
    logic [SLOT_W-1:0]  r_k;
    logic [SLOT_W-1:0]  n_k;
    logic [SCORE_W-1:0] r_cur_sc;
    logic [SCORE_W-1:0] n_cur_sc;
    logic [SLOT_W-1:0]  r_cur_id;
    logic [SLOT_W-1:0]  n_cur_id;
    logic               r_out_valid;
    logic               n_out_valid;
    t_out_res           r_out;
    t_out_res           n_out;

    logic [SLOT_W-1:0]  sc_ra;
    logic [SLOT_W-1:0]  sc_rb;
    logic [SLOT_W-1:0]  od_ra;
    logic [SLOT_W-1:0]  od_rb;
    logic               sc_we;
    logic [SLOT_W-1:0]  sc_wa;
    logic [SCORE_W-1:0] sc_wd;
    logic               od_we;
    logic [SLOT_W-1:0]  od_wa;
    logic [SLOT_W-1:0]  od_wd;
    logic               sc_clr;

    logic [SCORE_W-1:0] sc_a;
    logic [SCORE_W-1:0] sc_b;
    logic [SLOT_W-1:0]  od_a;
    logic [SLOT_W-1:0]  od_b;
    logic [SCORE_W:0]   sum_lo;
    logic [SCORE_W:0]   sum_hi;
    logic [SCORE_W-1:0] sat_lo;
    logic [SCORE_W-1:0] sat_hi;

    assign sc_a = r_sc_va ? r_sc_a : '0;
    assign sc_b = r_sc_vb ? r_sc_b : '0;
    assign od_a = r_od_va ? r_od_a : r_od_aa;
    assign od_b = r_od_vb ? r_od_b : r_od_ab;

    assign sum_lo = {1'b0, sc_a} + (SCORE_W + 1)'(r_cmd.s1);
    assign sum_hi = {1'b0, sc_b} + (SCORE_W + 1)'(r_cmd.s2);
    assign sat_lo = sum_lo[SCORE_W] ? '1 : sum_lo[SCORE_W-1:0];
    assign sat_hi = sum_hi[SCORE_W] ? '1 : sum_hi[SCORE_W-1:0];

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_cur_sc    = r_cur_sc;
        n_cur_id    = r_cur_id;
        n_out_valid = 1'b0;
        n_out       = r_out;
        o_pop       = 1'b0;
        sc_ra       = r_i;
        sc_rb       = r_j;
        od_ra       = r_i;
        od_rb       = r_j;
        sc_we       = 1'b0;
        sc_wa       = r_j;
        sc_wd       = r_cur_sc;
        od_we       = 1'b0;
        od_wa       = r_j;
        od_wd       = r_cur_id;
        sc_clr      = 1'b0;

        case (r_state)
            B_IDLE: begin
                sc_ra = i_cmd.low;
                sc_rb = i_cmd.high;
                od_ra = i_cmd.nxt_low;
                od_rb = i_cmd.nxt_high;
                if (i_valid) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    case (i_cmd.op)
                        CMD_START: begin
                            sc_clr  = 1'b1;
                            od_ra   = '0;
                            od_rb   = SLOT_W'(1);
                            n_state = B_PEMIT;
                        end
                        CMD_FIGHT: begin
                            n_state = B_ADD_LO;
                        end
                        default: begin
                            n_out_valid     = 1'b1;
                            n_out.kind      = KIND_ERROR;
                            n_out.first_id  = '0;
                            n_out.second_id = '0;
                            n_out.last      = 1'b1;
                        end
                    endcase
                end
            end
            B_PEMIT: begin
                n_out_valid     = 1'b1;
                n_out.kind      = KIND_FIGHT;
                n_out.first_id  = ID_W'(od_a);
                n_out.second_id = ID_W'(od_b);
                n_out.last      = 1'b1;
                n_state         = B_IDLE;
            end
            B_ADD_LO: begin
                sc_ra   = r_cmd.low;
                sc_rb   = r_cmd.high;
                od_ra   = r_cmd.nxt_low;
                od_rb   = r_cmd.nxt_high;
                sc_we   = 1'b1;
                sc_wa   = r_cmd.low;
                sc_wd   = sat_lo;
                n_state = B_ADD_HI;
            end
            B_ADD_HI: begin
                sc_ra = r_cmd.low;
                sc_rb = r_cmd.high;
                od_ra = r_cmd.nxt_low;
                od_rb = r_cmd.nxt_high;
                sc_we = 1'b1;
                sc_wa = r_cmd.high;
                sc_wd = sat_hi;
                if (r_cmd.last_pair) begin
                    n_i     = '0;
                    n_state = B_SLD;
                end else begin
                    n_out_valid     = 1'b1;
                    n_out.kind      = KIND_FIGHT;
                    n_out.first_id  = ID_W'(od_a);
                    n_out.second_id = ID_W'(od_b);
                    n_out.last      = 1'b1;
                    n_state         = B_IDLE;
                end
            end
            B_SLD: begin
                n_state = B_SCAP;
            end
            B_SCAP: begin
                n_cur_sc = sc_a;
                n_cur_id = od_a;
                n_j      = r_i + SLOT_W'(1);
                n_state  = B_SRD;
            end
            B_SRD: begin
                n_state = B_SCMP;
            end
            B_SCMP: begin
                // larger score moves to position i, old holder goes to j
                if (sc_b > r_cur_sc) begin
                    sc_we    = 1'b1;
                    od_we    = 1'b1;
                    n_cur_sc = sc_b;
                    n_cur_id = od_b;
                end
                if (r_j == SLOT_W'(POP_SIZE - 1)) begin
                    n_state = B_SWI;
                end else begin
                    n_j     = r_j + SLOT_W'(1);
                    n_state = B_SRD;
                end
            end
            B_SWI: begin
                sc_we = 1'b1;
                od_we = 1'b1;
                sc_wa = r_i;
                od_wa = r_i;
                if (r_i == SLOT_W'(POP_SIZE - 2)) begin
                    n_k     = '0;
                    n_state = B_BRD;
                end else begin
                    n_i     = r_i + SLOT_W'(1);
                    n_state = B_SLD;
                end
            end
            B_BRD: begin
                od_ra   = r_k;
                od_rb   = r_k + SLOT_W'(HALF_POP);
                n_state = B_BEMIT;
            end
            B_BEMIT: begin
                n_out_valid     = 1'b1;
                n_out.kind      = KIND_BREED;
                n_out.first_id  = ID_W'(od_a);
                n_out.second_id = ID_W'(od_b);
                n_out.last      = (r_k == SLOT_W'(HALF_POP - 1));
                if (r_k == SLOT_W'(HALF_POP - 1)) begin
                    n_state = B_IDLE;
                end else begin
                    n_k     = r_k + SLOT_W'(1);
                    n_state = B_BRD;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (sc_we) begin
            r_sc_mem[sc_wa] <= sc_wd;
        end
        if (od_we) begin
            r_od_mem[od_wa] <= od_wd;
        end
        r_sc_a  <= r_sc_mem[sc_ra];
        r_sc_b  <= r_sc_mem[sc_rb];
        r_od_a  <= r_od_mem[od_ra];
        r_od_b  <= r_od_mem[od_rb];
        r_od_aa <= od_ra;
        r_od_ab <= od_rb;
        r_cmd    <= n_cmd;
        r_i      <= n_i;
        r_j      <= n_j;
        r_k      <= n_k;
        r_cur_sc <= n_cur_sc;
        r_cur_id <= n_cur_id;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_vld    <= '0;
            r_od_vld    <= '0;
            r_sc_va     <= 1'b0;
            r_sc_vb     <= 1'b0;
            r_od_va     <= 1'b0;
            r_od_vb     <= 1'b0;
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_sc_va <= r_sc_vld[sc_ra];
            r_sc_vb <= r_sc_vld[sc_rb];
            r_od_va <= r_od_vld[od_ra];
            r_od_vb <= r_od_vld[od_rb];
            if (sc_clr) begin
                r_sc_vld <= '0;
            end else if (sc_we) begin
                r_sc_vld[sc_wa] <= 1'b1;
            end
            if (od_we) begin
                r_od_vld[od_wa] <= 1'b1;
            end
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> hw/rtl/round_robin_score_rank_core.sv
// Path to o_valid, back end idle: a request is first registered in the command queue;
// a start result then comes from state B_PEMIT, a fight result from B_ADD_LO and
// B_ADD_HI, an error straight from B_IDLE; o_valid is registered. The final fight
// of a round runs the exchange sort, one slot compare at a time on the score store's
// registered read port, then breeding pairs; a 2-entry request queue absorbs bursts.
// Reset (sync, active low): scores zero, order identity, round closed.
module round_robin_score_rank_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  rrsr_pkg::t_in_req  i_req,
    output logic               o_valid,
    output rrsr_pkg::t_out_res o_res
);
    import rrsr_pkg::*;

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic q_valid;
    logic q_full;
    logic q_pop;
    logic push;

    assign busy = q_full;
    assign push = start && !q_full;

    rrsr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (i_req),
        .o_cmd   (front_cmd)
    );

    rrsr_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (head_cmd)
    );

    rrsr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_cmd       (head_cmd),
        .o_pop       (q_pop),
        .o_res_valid (o_valid),
        .o_res       (o_res)
    );

endmodule

>>> tb/rrsr_pair_check.sv
`timescale 1ns / 1ps
module rrsr_pair_check (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  rrsr_pkg::t_in_req  i_req,
    input  logic               o_valid,
    input  rrsr_pkg::t_out_res o_res,
    output int                 o_fail_cnt,
    output int                 o_pending
);
    import rrsr_pkg::*;

    logic [SCORE_W-1:0] slot_pts [POP_SIZE];
    logic [ID_W-1:0]    slot_id  [POP_SIZE];
    int                 lo_slot;
    int                 hi_slot;
    logic               round_live;
    t_out_res           pair_q [$];

    initial begin
        o_fail_cnt = 0;
        o_pending  = 0;
    end

    task automatic report_bad(input string what, input t_out_res want, input t_out_res got);
        string exp_s;
        o_fail_cnt++;
        if (o_fail_cnt <= 10) begin
            exp_s = $sformatf("kind %0d ids %0d/%0d last %0d",
                              want.kind, want.first_id, want.second_id, want.last);
            $display("%0t %s: expected %s, got kind %0d ids %0d/%0d last %0d",
                     $time, what, exp_s, got.kind, got.first_id, got.second_id, got.last);
        end
    endtask

    task automatic push_pair(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] a,
                             input logic [ID_W-1:0] b, input logic last);
        t_out_res res;
        res.kind      = kind;
        res.first_id  = a;
        res.second_id = b;
        res.last      = last;
        pair_q.push_back(res);
    endtask

    function automatic logic [SCORE_W-1:0] sat_sum(input logic [SCORE_W-1:0] acc,
                                                   input logic [IN_SCORE_W-1:0] pts);
        logic [SCORE_W:0] sum;
        sum = {1'b0, acc} + (SCORE_W + 1)'(pts);
        return sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
    endfunction

    // descending exchange sort, ids follow their scores
    task automatic rank_slots();
        logic [SCORE_W-1:0] tp;
        logic [ID_W-1:0]    ti;
        for (int i = 0; i < POP_SIZE; i++) begin
            for (int j = i + 1; j < POP_SIZE; j++) begin
                if (slot_pts[j] > slot_pts[i]) begin
                    tp          = slot_pts[j];
                    slot_pts[j] = slot_pts[i];
                    slot_pts[i] = tp;
                    ti          = slot_id[j];
                    slot_id[j]  = slot_id[i];
                    slot_id[i]  = ti;
                end
            end
        end
    endtask

    task automatic predict_pairs(input t_in_req req);
        if (req.operation == OPER_START) begin
            foreach (slot_pts[k]) slot_pts[k] = '0;
            lo_slot    = 0;
            hi_slot    = 1;
            round_live = 1'b1;
            push_pair(KIND_FIGHT, slot_id[0], slot_id[1], 1'b1);
        end else if (!round_live) begin
            push_pair(KIND_ERROR, '0, '0, 1'b1);
        end else begin
            slot_pts[lo_slot] = sat_sum(slot_pts[lo_slot], req.first_score);
            slot_pts[hi_slot] = sat_sum(slot_pts[hi_slot], req.second_score);
            hi_slot++;
            if (hi_slot >= POP_SIZE) begin
                lo_slot++;
                hi_slot = lo_slot + 1;
            end
            if (hi_slot < POP_SIZE) begin
                push_pair(KIND_FIGHT, slot_id[lo_slot], slot_id[hi_slot], 1'b1);
            end else begin
                rank_slots();
                round_live = 1'b0;
                for (int k = 0; k < HALF_POP; k++) begin
                    push_pair(KIND_BREED, slot_id[k], slot_id[HALF_POP + k], k == HALF_POP - 1);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_res want;
        if (!i_rst_n) begin
            foreach (slot_pts[k]) begin
                slot_pts[k] = '0;
                slot_id[k]  = ID_W'(k);
            end
            lo_slot    = 0;
            hi_slot    = 1;
            round_live = 1'b0;
            pair_q.delete();
        end else begin
            // results never come from the request taken at this same edge
            if (o_valid) begin
                if (pair_q.size() == 0) begin
                    report_bad("unexpected result", '0, o_res);
                end else begin
                    want = pair_q.pop_front();
                    if (o_res.kind != want.kind || o_res.first_id != want.first_id ||
                        o_res.second_id != want.second_id || o_res.last != want.last) begin
                        report_bad("result mismatch", want, o_res);
                    end
                end
            end
            if (start && !busy) begin
                predict_pairs(i_req);
            end
        end
        o_pending = pair_q.size();
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import rrsr_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 400;
    localparam int NUM_PAIRS    = POP_SIZE * (POP_SIZE - 1) / 2;

    typedef enum {
        MIX_FULL,
        MIX_TINY,
        MIX_EDGE
    } t_score_mix;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    logic     busy;
    t_in_req  i_req   = '0;
    logic     o_valid;
    t_out_res o_res;
    int       fail_cnt;
    int       pending;
    int       cycle_cnt = 0;
    bit       no_idle   = 1'b0;

    always #5 i_clk = ~i_clk;

    round_robin_score_rank_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    rrsr_pair_check u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .o_res      (o_res),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [IN_SCORE_W-1:0] pick_score(input t_score_mix mix);
        case (mix)
            MIX_TINY: return IN_SCORE_W'($urandom_range(0, 3));
            MIX_EDGE: return $urandom_range(0, 1) ? '1 : '0;
            default:  return IN_SCORE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic send_req(input logic op, input logic [IN_SCORE_W-1:0] a,
                            input logic [IN_SCORE_W-1:0] b);
        t_in_req req;
        while (!no_idle && $urandom_range(0, 99) < 17) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        req.operation    = op;
        req.first_score  = a;
        req.second_score = b;
        start <= 1'b1;
        i_req <= req;
        // busy only moves at a rising edge, so its value here holds for the next one
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic play_fights(input int n, input t_score_mix mix);
        for (int k = 0; k < n; k++) begin
            send_req(OPER_FIGHT, pick_score(mix), pick_score(mix));
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // fight requests before any round opens, then a start and four fights
        send_req(OPER_FIGHT, '1, '1);
        send_req(OPER_FIGHT, '0, '0);
        send_req(OPER_START, '1, '0);
        send_req(OPER_FIGHT, '1, '1);
        send_req(OPER_FIGHT, '0, '0);
        send_req(OPER_FIGHT, '1, '0);
        send_req(OPER_FIGHT, '0, '1);
        // restart inside an open round
        send_req(OPER_START, 16'h5555, 16'hAAAA);
        send_req(OPER_FIGHT, 16'h8000, 16'h7FFF);
        send_req(OPER_FIGHT, 16'h5555, 16'hAAAA);

        for (int r = 0; r < 3; r++) begin
            no_idle = (r == 1);
            send_req(OPER_START, pick_score(MIX_FULL), pick_score(MIX_FULL));
            if (r == 0 || $urandom_range(0, 1)) begin
                play_fights($urandom_range(1, 60), t_score_mix'(r));
                send_req(OPER_START, pick_score(MIX_FULL), pick_score(MIX_FULL));
            end
            play_fights(NUM_PAIRS, t_score_mix'(r));
            play_fights($urandom_range(1, 3), MIX_FULL);
        end
        no_idle = 1'b0;

        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> round_robin_score_rank_core.f
hw/rtl/rrsr_pkg.sv
hw/rtl/rrsr_front.sv
hw/rtl/rrsr_cmd_q.sv
hw/rtl/rrsr_back.sv
hw/rtl/round_robin_score_rank_core.sv
tb/rrsr_pair_check.sv
tb/tb_top.sv
